>>> src/gyif_pkg.sv
// Shared constants and types for the gyro yaw integrator filter.
package gyif_pkg;

    localparam int WINDOW_LEN = 5;

    localparam int POS_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int REM_W = $clog2(WINDOW_LEN);
    localparam int SUM_W = 64 + $clog2(WINDOW_LEN);

    // Quotient bits retired per divider cycle.
    localparam int DIV_RADIX_BITS = 4;
    localparam int DIV_W = ((SUM_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS) * DIV_RADIX_BITS;
    localparam int DIV_STEPS = DIV_W / DIV_RADIX_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam int PADDR_W = 4;

    // Register indexes (byte address / 4).
    localparam logic [1:0] REG_RATE_OFFSET = 2'd0;
    localparam logic [1:0] REG_RATE_SCALE  = 2'd1;
    localparam logic [1:0] REG_DEF_INTERVAL = 2'd2;

    localparam logic [23:0] RATE_OFFSET_RST  = 24'd0;
    localparam logic [23:0] RATE_SCALE_RST   = 24'd67109;
    localparam logic [19:0] DEF_INTERVAL_RST = 20'd10000;

    typedef logic [63:0] angle_t;
    typedef logic [SUM_W-1:0] wsum_t;

    localparam angle_t HALF_TURN = 64'h0000_00B4_0000_0000;
    localparam angle_t FULL_TURN = 64'h0000_0168_0000_0000;

endpackage

>>> src/gyro_yaw_integrator_filter.sv
// Gyro yaw integrator: scaled rate integration, moving-average window, unwrap.
// Items are worked one at a time through the shared 24x32 multiplier (three passes)
// and the radix-16 mean divider (DIV_STEPS passes); a new item is taken only when idle.
// in_stall is high while an item is being worked; a result held in the output register
// does not block intake, but the done step holds until the output register can take it.
// Reset: async active low; clears accumulators, window, timestamp and loads register defaults.
module gyro_yaw_integrator_filter
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [15:0]            rate_sample,
    input  logic [31:0]                   timestamp_us,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [63:0]            yaw,
    output logic signed [63:0]            raw_angle,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gyif_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL0  = 4'd1;
    localparam logic [3:0] S_MUL1  = 4'd2;
    localparam logic [3:0] S_MUL2  = 4'd3;
    localparam logic [3:0] S_RND   = 4'd4;
    localparam logic [3:0] S_ACC   = 4'd5;
    localparam logic [3:0] S_WIN   = 4'd6;
    localparam logic [3:0] S_ABS   = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_ROUND = 4'd9;
    localparam logic [3:0] S_DELTA = 4'd10;
    localparam logic [3:0] S_WRAP  = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    localparam logic [gyif_pkg::REM_W:0] LEN_R = (gyif_pkg::REM_W + 1)'(gyif_pkg::WINDOW_LEN);
    localparam logic [gyif_pkg::POS_W-1:0] POS_LAST =
        gyif_pkg::POS_W'(gyif_pkg::WINDOW_LEN - 1);
    localparam logic [gyif_pkg::DIV_CNT_W-1:0] DIV_LAST =
        gyif_pkg::DIV_CNT_W'(gyif_pkg::DIV_STEPS - 1);

    // Control and architectural state
    logic [3:0]                      state_reg, state_next;
    logic                            out_valid_reg, out_valid_next;
    logic [23:0]                     rate_offset_reg, rate_offset_next;
    logic [23:0]                     rate_scale_reg, rate_scale_next;
    logic [19:0]                     def_interval_reg, def_interval_next;
    logic [31:0]                     last_stamp_reg, last_stamp_next;
    logic [31:0]                     interval_reg, interval_next;
    gyif_pkg::angle_t                angle_sum_reg, angle_sum_next;
    gyif_pkg::angle_t                last_yaw_reg, last_yaw_next;
    gyif_pkg::angle_t                window_reg [gyif_pkg::WINDOW_LEN];
    gyif_pkg::angle_t                window_next [gyif_pkg::WINDOW_LEN];
    logic [gyif_pkg::POS_W-1:0]      pos_reg, pos_next;
    gyif_pkg::wsum_t                 wsum_reg, wsum_next;
    logic [gyif_pkg::DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;

    // Datapath registers
    logic [23:0]                     dmag_reg, dmag_next;
    logic                            dneg_reg, dneg_next;
    logic [47:0]                     m_reg, m_next;
    logic [55:0]                     hi_reg, hi_next;
    logic [55:0]                     lo_reg, lo_next;
    gyif_pkg::angle_t                r_reg, r_next;
    logic                            mneg_reg, mneg_next;
    logic [gyif_pkg::DIV_W-1:0]      quo_reg, quo_next;
    logic [gyif_pkg::REM_W-1:0]      rem_reg, rem_next;
    gyif_pkg::angle_t                mean_reg, mean_next;
    gyif_pkg::angle_t                delta_reg, delta_next;
    gyif_pkg::angle_t                yaw_reg, yaw_next;
    gyif_pkg::angle_t                raw_reg, raw_next;

    // Shared multiplier
    logic [23:0]                     mul_a;
    logic [31:0]                     mul_b;
    logic [55:0]                     mul_p;

    logic                            in_xfer;
    logic                            cfg_wr;
    logic [1:0]                      cfg_idx;
    logic [24:0]                     diff;
    logic [24:0]                     diff_neg;
    logic                            slot_free;
    gyif_pkg::wsum_t                 wsum_neg;
    logic [gyif_pkg::REM_W:0]        dstep;
    logic [gyif_pkg::REM_W-1:0]      drem;
    logic [gyif_pkg::DIV_W-1:0]      dquo;
    gyif_pkg::angle_t                q_rnd;
    gyif_pkg::angle_t                q_neg;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign yaw       = yaw_reg;
    assign raw_angle = raw_reg;
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[3:2];
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        unique case (cfg_idx)
            gyif_pkg::REG_RATE_OFFSET:  prdata = {8'd0, rate_offset_reg};
            gyif_pkg::REG_RATE_SCALE:   prdata = {8'd0, rate_scale_reg};
            gyif_pkg::REG_DEF_INTERVAL: prdata = {12'd0, def_interval_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // Offset-corrected signed sample and its negation, 8 fractional bits
    assign diff     = {rate_sample[15], rate_sample, 8'd0} - {rate_offset_reg[23], rate_offset_reg};
    assign diff_neg = ~diff + 25'd1;

    always_comb
    begin
        unique case (state_reg)
            S_MUL0:
            begin
                mul_a = dmag_reg;
                mul_b = {8'd0, rate_scale_reg};
            end
            S_MUL1:
            begin
                mul_a = m_reg[47:24];
                mul_b = interval_reg;
            end
            default:
            begin
                mul_a = m_reg[23:0];
                mul_b = interval_reg;
            end
        endcase
    end

    assign mul_p = 56'(mul_a) * 56'(mul_b);

    assign wsum_neg = ~wsum_reg + gyif_pkg::SUM_W'(1);

    // Divider slice: DIV_RADIX_BITS restoring steps on a narrow remainder
    always_comb
    begin
        drem = rem_reg;
        dquo = quo_reg;
        dstep = '0;
        for (int k = 0; k < gyif_pkg::DIV_RADIX_BITS; k++)
        begin
            dstep = {drem, dquo[gyif_pkg::DIV_W-1]};
            dquo  = {dquo[gyif_pkg::DIV_W-2:0], 1'b0};
            if (dstep >= LEN_R)
            begin
                dstep   = dstep - LEN_R;
                dquo[0] = 1'b1;
            end
            drem = dstep[gyif_pkg::REM_W-1:0];
        end
    end

    // Round half away from zero on the magnitude, then restore the sign
    assign q_rnd = quo_reg[63:0] + (({rem_reg, 1'b0} >= LEN_R) ? 64'd1 : 64'd0);
    assign q_neg = ~q_rnd + 64'd1;

    always_comb
    begin
        state_next        = state_reg;
        out_valid_next    = out_valid_reg;
        rate_offset_next  = rate_offset_reg;
        rate_scale_next   = rate_scale_reg;
        def_interval_next = def_interval_reg;
        last_stamp_next   = last_stamp_reg;
        interval_next     = interval_reg;
        angle_sum_next    = angle_sum_reg;
        last_yaw_next     = last_yaw_reg;
        window_next       = window_reg;
        pos_next          = pos_reg;
        wsum_next         = wsum_reg;
        div_cnt_next      = div_cnt_reg;
        dmag_next         = dmag_reg;
        dneg_next         = dneg_reg;
        m_next            = m_reg;
        hi_next           = hi_reg;
        lo_next           = lo_reg;
        r_next            = r_reg;
        mneg_next         = mneg_reg;
        quo_next          = quo_reg;
        rem_next          = rem_reg;
        mean_next         = mean_reg;
        delta_next        = delta_reg;
        yaw_next          = yaw_reg;
        raw_next          = raw_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_wr)
        begin
            unique case (cfg_idx)
                gyif_pkg::REG_RATE_OFFSET:  rate_offset_next = pwdata[23:0];
                gyif_pkg::REG_RATE_SCALE:   rate_scale_next = pwdata[23:0];
                gyif_pkg::REG_DEF_INTERVAL:
                begin
                    def_interval_next = pwdata[19:0];
                    if (last_stamp_reg == 32'd0)
                    begin
                        interval_next = {12'd0, pwdata[19:0]};
                    end
                end
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (last_stamp_reg != 32'd0)
                    begin
                        interval_next = timestamp_us - last_stamp_reg;
                    end
                    last_stamp_next = timestamp_us;
                    dneg_next  = diff[24];
                    dmag_next  = diff[24] ? diff_neg[23:0] : diff[23:0];
                    state_next = S_MUL0;
                end
            end
            S_MUL0:
            begin
                m_next     = mul_p[47:0];
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                hi_next    = mul_p;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                lo_next    = mul_p;
                state_next = S_RND;
            end
            S_RND:
            begin
                r_next     = {hi_reg, 8'd0} + 64'((57'(lo_reg) + 57'h8000) >> 16);
                state_next = S_ACC;
            end
            S_ACC:
            begin
                angle_sum_next = dneg_reg ? angle_sum_reg - r_reg : angle_sum_reg + r_reg;
                // drop the entry about to be overwritten from the running sum
                wsum_next  = wsum_reg - {{(gyif_pkg::SUM_W-64){window_reg[pos_reg][63]}},
                                         window_reg[pos_reg]};
                state_next = S_WIN;
            end
            S_WIN:
            begin
                window_next[pos_reg] = angle_sum_reg;
                wsum_next  = wsum_reg + {{(gyif_pkg::SUM_W-64){angle_sum_reg[63]}},
                                         angle_sum_reg};
                pos_next   = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
                state_next = S_ABS;
            end
            S_ABS:
            begin
                mneg_next    = wsum_reg[gyif_pkg::SUM_W-1];
                quo_next     = gyif_pkg::DIV_W'(wsum_reg[gyif_pkg::SUM_W-1] ? wsum_neg : wsum_reg);
                rem_next     = '0;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                quo_next     = dquo;
                rem_next     = drem;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                mean_next  = mneg_reg ? q_neg : q_rnd;
                state_next = S_DELTA;
            end
            S_DELTA:
            begin
                delta_next = mean_reg - last_yaw_reg;
                state_next = S_WRAP;
            end
            S_WRAP:
            begin
                if ($signed(delta_reg) > $signed(gyif_pkg::HALF_TURN))
                begin
                    delta_next = delta_reg - gyif_pkg::FULL_TURN;
                end
                else if ($signed(delta_reg) < -$signed(gyif_pkg::HALF_TURN))
                begin
                    delta_next = delta_reg + gyif_pkg::FULL_TURN;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register can take the result
                if (slot_free)
                begin
                    last_yaw_next  = last_yaw_reg + delta_reg;
                    yaw_next       = last_yaw_reg + delta_reg;
                    raw_next       = angle_sum_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            out_valid_reg    <= 1'b0;
            rate_offset_reg  <= gyif_pkg::RATE_OFFSET_RST;
            rate_scale_reg   <= gyif_pkg::RATE_SCALE_RST;
            def_interval_reg <= gyif_pkg::DEF_INTERVAL_RST;
            last_stamp_reg   <= 32'd0;
            interval_reg     <= {12'd0, gyif_pkg::DEF_INTERVAL_RST};
            angle_sum_reg    <= '0;
            last_yaw_reg     <= '0;
            for (int i = 0; i < gyif_pkg::WINDOW_LEN; i++)
            begin
                window_reg[i] <= '0;
            end
            pos_reg          <= '0;
            wsum_reg         <= '0;
            div_cnt_reg      <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            out_valid_reg    <= out_valid_next;
            rate_offset_reg  <= rate_offset_next;
            rate_scale_reg   <= rate_scale_next;
            def_interval_reg <= def_interval_next;
            last_stamp_reg   <= last_stamp_next;
            interval_reg     <= interval_next;
            angle_sum_reg    <= angle_sum_next;
            last_yaw_reg     <= last_yaw_next;
            window_reg       <= window_next;
            pos_reg          <= pos_next;
            wsum_reg         <= wsum_next;
            div_cnt_reg      <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dmag_reg  <= dmag_next;
        dneg_reg  <= dneg_next;
        m_reg     <= m_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        r_reg     <= r_next;
        mneg_reg  <= mneg_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        mean_reg  <= mean_next;
        delta_reg <= delta_next;
        yaw_reg   <= yaw_next;
        raw_reg   <= raw_next;
    end

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result appeared outside the done step");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == S_MUL0))
        else $error("transfer did not start the multiply sequence");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("window position out of range");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_cnt_reg <= DIV_LAST))
        else $error("divider ran past its step count");

endmodule

>>> test/testbench.sv
// Testbench for the gyro yaw integrator: APB setup, sample stream and angle checks.
`timescale 1ns / 1ps

module testbench;

    localparam int DRAIN_CYCLES = 2 * (12 + gyif_pkg::DIV_STEPS);
    localparam int STALL_LIMIT = 4000;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic signed [15:0] rate;
        logic [31:0] stamp;
    } gyro_sample_t;

    typedef struct {
        gyif_pkg::angle_t yaw;
        gyif_pkg::angle_t raw;
    } angle_pair_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [15:0] rate_sample = '0;
    logic [31:0] timestamp_us = '0;

    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [63:0] yaw;
    logic signed [63:0] raw_angle;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [gyif_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    gyro_yaw_integrator_filter DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rate_sample(rate_sample),
        .timestamp_us(timestamp_us),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .yaw(yaw),
        .raw_angle(raw_angle),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #5 clk = ~clk;

    gyro_sample_t sample_fifo[$];
    angle_pair_t angle_fifo[$];
    int samples_queued = 0;
    int samples_taken = 0;
    int mismatches = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    logic [31:0] clock_us = '0;

    // Register copies and integrator state
    logic [23:0] cfg_offset = gyif_pkg::RATE_OFFSET_RST;
    logic [23:0] cfg_scale = gyif_pkg::RATE_SCALE_RST;
    logic [19:0] cfg_interval = gyif_pkg::DEF_INTERVAL_RST;
    logic [31:0] stamp_prev = '0;
    logic [31:0] interval_us = 32'(gyif_pkg::DEF_INTERVAL_RST);
    gyif_pkg::angle_t angle_acc = '0;
    gyif_pkg::angle_t ring[gyif_pkg::WINDOW_LEN] = '{default: '0};
    int ring_pos = 0;
    gyif_pkg::angle_t yaw_prev = '0;

    // Angle step in 2^-32 degree, kept mod 2^64.
    function automatic gyif_pkg::angle_t rate_increment(logic signed [15:0] rate,
                                                        logic [31:0] t);
        logic signed [63:0] rx, ox, sc, d, p;
        logic [63:0] m, mh, ml, r, tw;
        rx = rate;
        ox = {{40{cfg_offset[23]}}, cfg_offset};
        sc = {40'd0, cfg_scale};
        d = (rx <<< 8) - ox;
        p = d * sc;
        m = (p < 0) ? -p : p;
        mh = m >> 24;
        ml = {40'd0, m[23:0]};
        tw = {32'd0, t};
        r = ((mh * tw) << 8) + ((ml * tw + 64'h8000) >> 16);
        return (p < 0) ? (64'd0 - r) : r;
    endfunction

    // Window mean, rounded half away from zero.
    function automatic gyif_pkg::angle_t ring_mean();
        logic [71:0] total, mag, q, rem;
        logic neg;
        total = '0;
        for (int i = 0; i < gyif_pkg::WINDOW_LEN; i++)
            total = total + {{8{ring[i][63]}}, ring[i]};
        neg = total[71];
        mag = neg ? (72'd0 - total) : total;
        q = mag / 72'(gyif_pkg::WINDOW_LEN);
        rem = mag % 72'(gyif_pkg::WINDOW_LEN);
        if (2 * rem >= 72'(gyif_pkg::WINDOW_LEN))
            q = q + 1;
        return neg ? (64'd0 - q[63:0]) : q[63:0];
    endfunction

    task automatic integrate_sample(input logic signed [15:0] rate, input logic [31:0] stamp);
        gyif_pkg::angle_t delta;
        angle_pair_t res;
        if (stamp_prev != 0)
            interval_us = stamp - stamp_prev;
        stamp_prev = stamp;
        angle_acc = angle_acc + rate_increment(rate, interval_us);
        ring[ring_pos] = angle_acc;
        ring_pos = (ring_pos + 1) % gyif_pkg::WINDOW_LEN;
        delta = ring_mean() - yaw_prev;
        if (!delta[63] && delta > gyif_pkg::HALF_TURN)
            delta = delta - gyif_pkg::FULL_TURN;
        else if (delta[63] && delta < (64'd0 - gyif_pkg::HALF_TURN))
            delta = delta + gyif_pkg::FULL_TURN;
        yaw_prev = yaw_prev + delta;
        res.yaw = yaw_prev;
        res.raw = angle_acc;
        angle_fifo.push_back(res);
    endtask

    // Sample driver
    always @(posedge clk)
    begin : drive_proc
        gyro_sample_t item;
        if (in_valid && !in_stall)
        begin
            integrate_sample(rate_sample, timestamp_us);
            samples_taken++;
        end
        if (!in_valid || !in_stall)
        begin
            if (rst_n && sample_fifo.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                item = sample_fifo.pop_front();
                in_valid <= 1'b1;
                rate_sample <= item.rate;
                timestamp_us <= item.stamp;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result monitor
    always @(posedge clk)
    begin : check_proc
        angle_pair_t want;
        out_stall <= ($urandom_range(99) < stall_pct);
        if (rst_n && out_valid && !out_stall)
        begin
            if (angle_fifo.size() == 0)
            begin
                $display("%0t: unexpected result yaw=%h raw_angle=%h", $time, yaw, raw_angle);
                mismatches++;
            end
            else
            begin
                want = angle_fifo.pop_front();
                if (yaw !== want.yaw)
                begin
                    $display("%0t: yaw expected %h actual %h", $time, want.yaw, yaw);
                    mismatches++;
                end
                if (raw_angle !== want.raw)
                begin
                    $display("%0t: raw_angle expected %h actual %h", $time, want.raw,
                             raw_angle);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("gyro_yaw_integrator_filter test failed");
            $finish;
        end
    end

    task automatic add_sample(input logic signed [15:0] rate, input logic [31:0] stamp);
        gyro_sample_t item;
        item.rate = rate;
        item.stamp = stamp;
        sample_fifo.push_back(item);
        samples_queued++;
    endtask

    // Wait for all samples taken and all angles returned, then let the pipe go quiet.
    task automatic settle();
        while (samples_taken != samples_queued || angle_fifo.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            gyif_pkg::REG_RATE_OFFSET: cfg_offset = data[23:0];
            gyif_pkg::REG_RATE_SCALE: cfg_scale = data[23:0];
            gyif_pkg::REG_DEF_INTERVAL:
            begin
                cfg_interval = data[19:0];
                if (stamp_prev == 0)
                    interval_us = 32'(cfg_interval);
            end
            default: ;
        endcase
    endtask

    task automatic check_register(input logic [1:0] idx);
        logic [31:0] want, mask, got;
        case (idx)
            gyif_pkg::REG_RATE_OFFSET:
            begin
                want = 32'(cfg_offset);
                mask = 32'h00FF_FFFF;
            end
            gyif_pkg::REG_RATE_SCALE:
            begin
                want = 32'(cfg_scale);
                mask = 32'h00FF_FFFF;
            end
            default:
            begin
                want = 32'(cfg_interval);
                mask = 32'h000F_FFFF;
            end
        endcase
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if ((got & mask) !== want)
        begin
            $display("%0t: register %0d expected %h actual %h", $time, idx, want, got & mask);
            mismatches++;
        end
    endtask

    task automatic check_all_registers();
        check_register(gyif_pkg::REG_RATE_OFFSET);
        check_register(gyif_pkg::REG_RATE_SCALE);
        check_register(gyif_pkg::REG_DEF_INTERVAL);
    endtask

    function automatic logic signed [15:0] random_rate();
        case ($urandom_range(9))
            0: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            1, 2, 3: return 16'($urandom());
            default: return 16'($urandom_range(4000)) - 16'sd2000;
        endcase
    endfunction

    // Mostly steady time steps; now and then zero, a jump, a near-wrap or a repeat.
    function automatic logic [31:0] next_stamp();
        case ($urandom_range(19))
            0: clock_us = '0;
            1: clock_us = $urandom();
            2: clock_us = clock_us + $urandom_range(2);
            3: clock_us = 32'hFFFF_FFFF - $urandom_range(5000);
            default: clock_us = clock_us + $urandom_range(20000, 1);
        endcase
        return clock_us;
    endfunction

    task automatic random_config(input bit heavy);
        logic [31:0] ofs, scl, ivl;
        int pick;
        ofs = $urandom();
        pick = $urandom_range(3);
        if (pick == 0)
            ofs[23:0] = 24'h80_0000;
        else if (pick == 1)
            ofs[23:0] = 24'h7F_FFFF;
        else if (pick == 2)
            ofs[23:0] = 24'($urandom_range(20000)) - 24'd10000;
        scl = $urandom();
        pick = $urandom_range(3);
        if (!heavy)
            scl[23:0] = 24'($urandom_range(140000, 30000));
        else if (pick == 0)
            scl[23:0] = '0;
        else if (pick == 1)
            scl[23:0] = 24'hFF_FFFF;
        ivl = $urandom();
        pick = $urandom_range(3);
        if (pick == 0)
            ivl[19:0] = 20'd1;
        else if (pick == 1)
            ivl[19:0] = 20'd1000000;
        else
            ivl[19:0] = 20'($urandom_range(1000000, 1));
        write_register(gyif_pkg::REG_RATE_OFFSET, ofs);
        write_register(gyif_pkg::REG_RATE_SCALE, scl);
        write_register(gyif_pkg::REG_DEF_INTERVAL, ivl);
        if ($urandom_range(1))
            write_register(REG_UNUSED, $urandom());
        check_all_registers();
    endtask

    initial
    begin : stimulus
        bit heavy;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values, and stored zero stamps that keep the default interval
        check_all_registers();
        add_sample(16'sd0, 32'd0);
        add_sample(16'sh7FFF, 32'd0);
        settle();

        // Interval write while no stamp is stored loads the interval; bad index is dropped
        write_register(gyif_pkg::REG_DEF_INTERVAL, 32'd1);
        write_register(REG_UNUSED, 32'hFFFF_FFFF);
        check_all_registers();
        add_sample(16'sh8000, 32'hFFFF_FFFF);
        add_sample(-16'sd1, 32'd5);
        add_sample(16'sd1, 32'd5);
        settle();

        // Extreme registers: huge increments and accumulator wrap
        write_register(gyif_pkg::REG_DEF_INTERVAL, 32'd1000000);
        write_register(gyif_pkg::REG_RATE_OFFSET, 32'h007F_FFFF);
        write_register(gyif_pkg::REG_RATE_SCALE, 32'h00FF_FFFF);
        check_all_registers();
        add_sample(16'sh8000, 32'h7FFF_FFFF);
        add_sample(16'sh7FFF, 32'hFFFF_FFFE);
        add_sample(16'sh8000, 32'h7FFF_FFFD);
        add_sample(16'sh8000, 32'd0);
        add_sample(16'sh7FFF, 32'd100);
        add_sample(16'sd5, 32'd0);
        settle();

        write_register(gyif_pkg::REG_RATE_OFFSET, 32'h0080_0000);
        write_register(gyif_pkg::REG_DEF_INTERVAL, 32'd1000000);
        check_all_registers();
        add_sample(16'sh7FFF, 32'd1234);
        add_sample(16'sh8000, 32'hFFFF_0000);
        add_sample(16'sd12345, 32'hFFFF_0010);
        settle();

        // Zero scale
        write_register(gyif_pkg::REG_RATE_SCALE, 32'd0);
        check_register(gyif_pkg::REG_RATE_SCALE);
        add_sample(16'sh7FFF, 32'hFFFF_2000);
        add_sample(16'sh8000, 32'hFFFF_4000);
        settle();

        for (int phase = 0; phase < 8; phase++)
        begin
            heavy = (phase >= 4) ^ phase[0];
            case (phase % 4)
                0:
                begin
                    idle_pct <= 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    idle_pct <= 64;
                    stall_pct <= 0;
                end
                2:
                begin
                    idle_pct <= 0;
                    stall_pct <= 64;
                end
                default:
                begin
                    idle_pct <= 36;
                    stall_pct <= 36;
                end
            endcase
            random_config(heavy);
            for (int n = 0; n < 212; n++)
                add_sample(random_rate(), next_stamp());
            settle();
        end

        if (mismatches == 0)
            $display("gyro_yaw_integrator_filter test passed");
        else
            $display("gyro_yaw_integrator_filter test failed");
        $finish;
    end

endmodule

>>> gyro_yaw_integrator_filter.f
src/gyif_pkg.sv
src/gyro_yaw_integrator_filter.sv
test/testbench.sv
